@@ src/biquad_pkg.sv @@
// shared types and constants of the biquad filter
`default_nettype none

package biquad_pkg;

  localparam int CFG_IDX_W = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_COEF_B0 = 3'd0;
  localparam cfg_idx_t CFG_COEF_B1 = 3'd1;
  localparam cfg_idx_t CFG_COEF_B2 = 3'd2;
  localparam cfg_idx_t CFG_COEF_A1 = 3'd3;
  localparam cfg_idx_t CFG_COEF_A2 = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_B0,
    S_ADD_D1,
    S_ROUND,
    S_OUT,
    S_MUL_A1,
    S_SUB_A1,
    S_ADD_D2,
    S_SUB_A2
  } state_e;

endpackage

`default_nettype wire

@@ src/biquad_if.sv @@
// stream and configuration channel interfaces of the biquad filter
`default_nettype none

interface biquad_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface biquad_out_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

interface biquad_cfg_if
  import biquad_pkg::*;
#(
  parameter int COEF_WIDTH = 24
);
  logic                  valid;
  logic                  ready;
  cfg_idx_t              index;
  logic [COEF_WIDTH-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ src/biquad_iir_filter_core.sv @@
// biquad iir section in transposed direct form ii with a shared multiplier
`default_nettype none

// One sample is taken per transfer on the input channel; the block then runs
// eight sequencer steps through one COEF_WIDTH x SAMPLE_WIDTH multiplier and
// one accumulator adder, so a new sample is accepted only once the sequencer
// is idle again. The filtered sample is offered on the output register and
// is held until taken; if the previous result is still waiting at that point
// the sequencer holds until it is transferred. Coefficients are signed
// Q(COEF_WIDTH-COEF_FRAC_BITS).COEF_FRAC_BITS words written by index (b0, b1,
// b2, a1, a2); the user must write them only while the block is idle, which
// the block does not enforce. b0 resets to unity and the rest to zero. The
// output is rounded half up and saturated, and both delay states saturate.
module biquad_iir_filter_core
  import biquad_pkg::*;
#(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_WIDTH     = 24,
  parameter int COEF_FRAC_BITS = 20
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  biquad_in_if.sink    in_ch_i,
  biquad_out_if.source out_ch_o,
  biquad_cfg_if.sink   cfg_ch_i
);

  localparam int PROD_W  = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int DELAY_W = (PROD_W + 2 > 62) ? 62 : PROD_W + 2;
  localparam int ACC_W   = (PROD_W + 3 > 65) ? PROD_W + 3 : 65;

  localparam longint unsigned ONE_FULL = 64'd1 << COEF_FRAC_BITS;
  localparam logic [COEF_WIDTH-1:0] COEF_ONE = ONE_FULL[COEF_WIDTH-1:0];

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
  localparam logic signed [ACC_W-1:0] S64_MAX = {{(ACC_W-63){1'b0}}, {63{1'b1}}};
  localparam logic signed [ACC_W-1:0] S64_MIN = {{(ACC_W-63){1'b1}}, {63{1'b0}}};
  localparam logic signed [ACC_W-1:0] DLY_MAX =
    {{(ACC_W-DELAY_W+1){1'b0}}, {(DELAY_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] DLY_MIN =
    {{(ACC_W-DELAY_W+1){1'b1}}, {(DELAY_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] SMP_MAX =
    {{(ACC_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SMP_MIN =
    {{(ACC_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

  function automatic logic signed [ACC_W-1:0] sat64(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    if (v > S64_MAX) begin
      r = S64_MAX;
    end else if (v < S64_MIN) begin
      r = S64_MIN;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic signed [DELAY_W-1:0] sat_dly(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    if (v > DLY_MAX) begin
      r = DLY_MAX;
    end else if (v < DLY_MIN) begin
      r = DLY_MIN;
    end else begin
      r = v;
    end
    return r[DELAY_W-1:0];
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] sat_smp(
    input logic signed [ACC_W-1:0] v
  );
    logic signed [ACC_W-1:0] r;
    if (v > SMP_MAX) begin
      r = SMP_MAX;
    end else if (v < SMP_MIN) begin
      r = SMP_MIN;
    end else begin
      r = v;
    end
    return r[SAMPLE_WIDTH-1:0];
  endfunction

  state_e state_q, state_d;

  logic signed [COEF_WIDTH-1:0]   coef_b0_q, coef_b1_q, coef_b2_q, coef_a1_q, coef_a2_q;
  logic signed [SAMPLE_WIDTH-1:0] x_q, x_d;
  logic signed [SAMPLE_WIDTH-1:0] y_q, y_d;
  logic signed [PROD_W-1:0]       prod_q;
  logic signed [ACC_W-1:0]        acc_q, acc_d;
  logic signed [DELAY_W-1:0]      dly1_q, dly1_d;
  logic signed [DELAY_W-1:0]      dly2_q, dly2_d;
  logic                           out_valid_q, out_valid_d;

  logic signed [COEF_WIDTH-1:0]   mul_coef;
  logic signed [SAMPLE_WIDTH-1:0] mul_op;
  logic signed [PROD_W-1:0]       mul_res;
  logic signed [ACC_W-1:0]        add_a, add_b, add_sum;
  logic signed [ACC_W-1:0]        prod_ext, acc_shift;

  // coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_b0_q <= COEF_ONE;
      coef_b1_q <= '0;
      coef_b2_q <= '0;
      coef_a1_q <= '0;
      coef_a2_q <= '0;
    end else if (cfg_ch_i.valid && cfg_ch_i.ready) begin
      case (cfg_ch_i.index)
        CFG_COEF_B0: coef_b0_q <= cfg_ch_i.data;
        CFG_COEF_B1: coef_b1_q <= cfg_ch_i.data;
        CFG_COEF_B2: coef_b2_q <= cfg_ch_i.data;
        CFG_COEF_A1: coef_a1_q <= cfg_ch_i.data;
        CFG_COEF_A2: coef_a2_q <= cfg_ch_i.data;
        default: begin
        end
      endcase
    end
  end

  assign cfg_ch_i.ready = 1'b1;

  // shared multiplier
  always_comb begin
    case (state_q)
      S_OUT: begin
        mul_coef = coef_b1_q;
        mul_op   = x_q;
      end
      S_MUL_A1: begin
        mul_coef = coef_a1_q;
        mul_op   = y_q;
      end
      S_SUB_A1: begin
        mul_coef = coef_b2_q;
        mul_op   = x_q;
      end
      S_ADD_D2: begin
        mul_coef = coef_a2_q;
        mul_op   = y_q;
      end
      default: begin
        mul_coef = coef_b0_q;
        mul_op   = x_q;
      end
    endcase
  end

  assign mul_res   = PROD_W'(mul_coef) * PROD_W'(mul_op);
  assign prod_ext  = ACC_W'(prod_q);
  assign acc_shift = acc_q >>> COEF_FRAC_BITS;

  // shared accumulator adder
  always_comb begin
    case (state_q)
      S_ADD_D1: begin
        add_a = prod_ext;
        add_b = ACC_W'(dly1_q);
      end
      S_ROUND: begin
        add_a = acc_q;
        add_b = ROUND_HALF;
      end
      S_ADD_D2: begin
        add_a = acc_q;
        add_b = ACC_W'(dly2_q);
      end
      default: begin
        add_a = acc_q;
        add_b = -prod_ext;
      end
    endcase
  end

  assign add_sum = add_a + add_b;

  // sequencer
  always_comb begin
    state_d     = state_q;
    x_d         = x_q;
    y_d         = y_q;
    acc_d       = acc_q;
    dly1_d      = dly1_q;
    dly2_d      = dly2_q;
    out_valid_d = out_valid_q;

    if (out_valid_q && out_ch_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_ch_i.valid) begin
          x_d     = in_ch_i.sample_in;
          state_d = S_MUL_B0;
        end
      end
      S_MUL_B0: begin
        state_d = S_ADD_D1;
      end
      S_ADD_D1: begin
        acc_d   = sat64(add_sum);
        state_d = S_ROUND;
      end
      S_ROUND: begin
        acc_d   = sat64(add_sum);
        state_d = S_OUT;
      end
      S_OUT: begin
        // hold while the previous sample is still waiting
        if (!out_valid_q || out_ch_o.ready) begin
          y_d         = sat_smp(acc_shift);
          out_valid_d = 1'b1;
          state_d     = S_MUL_A1;
        end
      end
      S_MUL_A1: begin
        acc_d   = prod_ext;
        state_d = S_SUB_A1;
      end
      S_SUB_A1: begin
        acc_d   = sat64(add_sum);
        state_d = S_ADD_D2;
      end
      S_ADD_D2: begin
        dly1_d  = sat_dly(add_sum);
        acc_d   = prod_ext;
        state_d = S_SUB_A2;
      end
      S_SUB_A2: begin
        dly2_d  = sat_dly(add_sum);
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      dly1_q      <= '0;
      dly2_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      dly1_q      <= dly1_d;
      dly2_q      <= dly2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    acc_q  <= acc_d;
    prod_q <= mul_res;
  end

  assign in_ch_i.ready       = (state_q == S_IDLE);
  assign out_ch_o.valid      = out_valid_q;
  assign out_ch_o.sample_out = y_q;

endmodule

`default_nettype wire

@@ src/biquad_checker.sv @@
// port-level assertions of the biquad filter and their binding
`default_nettype none

module biquad_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i
);

  logic in_xfer;

  assign in_xfer = in_valid_i && in_ready_i;

  // a sample keeps the sequencer busy, with the input not ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_i ##1 !in_ready_i ##1 !in_ready_i ##1 !in_ready_i
                ##1 !in_ready_i ##1 !in_ready_i ##1 !in_ready_i ##1 !in_ready_i)
    else $error("input taken while a sample is in progress");

  // a new result only appears while a sample is being worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !in_ready_i)
    else $error("result appeared with the sequencer idle");

  // no new result appears before the sample of an input transfer reaches the output step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !$rose(out_valid_i) ##1 !$rose(out_valid_i) ##1 !$rose(out_valid_i))
    else $error("result appeared too early");

  // a pending result stays until transferred
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transfer");

endmodule

bind biquad_iir_filter_core biquad_checker u_biquad_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch_i.valid),
  .in_ready_i  (in_ch_i.ready),
  .out_valid_i (out_ch_o.valid),
  .out_ready_i (out_ch_o.ready)
);

`default_nettype wire
